/* hw/rtl/qvr_pkg.sv */
`default_nettype none

package qvr_pkg;

   localparam int COMP_W  = 16;
   localparam int FRAC_W  = 14;
   localparam int PROD1_W = 2 * COMP_W;
   localparam int PR_W    = PROD1_W + 2;
   localparam int PROD2_W = COMP_W + PR_W;
   localparam int ACC_W   = PROD2_W + 2;
   localparam int SHIFT_W = 2 * FRAC_W;
   localparam int Q_W     = ACC_W - SHIFT_W;
   localparam int IDX_W   = 8;

   typedef logic signed [COMP_W-1:0] comp_type;
   typedef logic signed [PR_W-1:0]   pr_comp_type;
   typedef logic signed [ACC_W-1:0]  acc_comp_type;
   typedef logic [IDX_W-1:0]         csr_idx_type;

   // rotation quaternion, scalar then i, j, k
   typedef struct packed {
      comp_type w;
      comp_type x;
      comp_type y;
      comp_type z;
   } quat_type;

   typedef struct packed {
      pr_comp_type w;
      pr_comp_type x;
      pr_comp_type y;
      pr_comp_type z;
   } pr_type;

   typedef struct packed {
      acc_comp_type x;
      acc_comp_type y;
      acc_comp_type z;
   } acc_type;

   localparam comp_type ONE_Q14 = comp_type'(16384);

   localparam csr_idx_type REG_ROT_W = csr_idx_type'(0);
   localparam csr_idx_type REG_ROT_X = csr_idx_type'(1);
   localparam csr_idx_type REG_ROT_Y = csr_idx_type'(2);
   localparam csr_idx_type REG_ROT_Z = csr_idx_type'(3);

endpackage

`default_nettype wire

/* hw/rtl/quaternion_vector_rotate.sv */
// Quaternion vector rotation, one 16-bit signed 3-vector per transfer.
// Request channel: req_valid with req_vec_x/y/z; a transfer happens when
// req_valid is high and req_stall is low. Response channel: rsp_valid with
// rsp_out_x/y/z and rsp_clipped, taken when rsp_stall is low. Each request
// gives exactly one response, in order.
// The result is the vector part of conj(r) * (1,v) * r, r in Q1.14, scaled
// down by 2^28 toward zero and clamped to 16 bits; rsp_clipped marks a clamp.
// The csr channel writes rot_w, rot_x, rot_y, rot_z at index 0..3, with
// csr_ready always high; other indices are dropped. Write only while idle.
// Between request transfer and response transfer lie the registered stages:
// two for the first quaternion product, two for the second, and one for
// scaling and clamping. Throughput is one vector per cycle while rsp_stall
// is low; each multiplier stage is registered.
// Reset (synchronous) empties the pipeline and loads r = (1.0, 0, 0, 0).
// When rsp_stall is high the held response stays put and the stages behind
// it keep filling any bubbles; req_stall rises only once all stages hold data.
`default_nettype none

module quaternion_vector_rotate
   import qvr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire comp_type    req_vec_x,
   input  wire comp_type    req_vec_y,
   input  wire comp_type    req_vec_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output comp_type         rsp_out_x,
   output comp_type         rsp_out_y,
   output comp_type         rsp_out_z,
   output logic             rsp_clipped,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire csr_idx_type csr_index,
   input  wire comp_type    csr_data
);

   quat_type rot;
   logic left_ready, left_valid;
   logic right_ready, right_valid;
   logic sat_ready;
   pr_type  pr;
   acc_type acc;

   qvr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rot       (rot)
   );

   qvr_ham_left u_left (
      .clock     (clock),
      .reset     (reset),
      .rot       (rot),
      .in_valid  (req_valid),
      .in_ready  (left_ready),
      .in_x      (req_vec_x),
      .in_y      (req_vec_y),
      .in_z      (req_vec_z),
      .out_valid (left_valid),
      .out_ready (right_ready),
      .out_pr    (pr)
   );

   qvr_ham_right u_right (
      .clock     (clock),
      .reset     (reset),
      .rot       (rot),
      .in_valid  (left_valid),
      .in_ready  (right_ready),
      .in_pr     (pr),
      .out_valid (right_valid),
      .out_ready (sat_ready),
      .out_acc   (acc)
   );

   qvr_round_sat u_sat (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (right_valid),
      .in_ready    (sat_ready),
      .in_acc      (acc),
      .out_valid   (rsp_valid),
      .out_ready   (!rsp_stall),
      .out_x       (rsp_out_x),
      .out_y       (rsp_out_y),
      .out_z       (rsp_out_z),
      .out_clipped (rsp_clipped)
   );

   assign req_stall = !left_ready;

endmodule

`default_nettype wire

/* hw/rtl/qvr_csr.sv */
`default_nettype none

module qvr_csr
   import qvr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire csr_idx_type csr_index,
   input  wire comp_type    csr_data,
   output quat_type         rot
);

   quat_type rot_ff;
   quat_type rot_in;

   assign csr_ready = 1'b1;
   assign rot       = rot_ff;

   always_comb begin
      rot_in = rot_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_ROT_W: rot_in.w = csr_data;
            REG_ROT_X: rot_in.x = csr_data;
            REG_ROT_Y: rot_in.y = csr_data;
            REG_ROT_Z: rot_in.z = csr_data;
            default:   rot_in = rot_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_ff.w <= ONE_Q14;
         rot_ff.x <= '0;
         rot_ff.y <= '0;
         rot_ff.z <= '0;
      end else begin
         rot_ff <= rot_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/qvr_ham_left.sv */
`default_nettype none

// p * r with p = (1, v): products in the first stage, sums in the second
module qvr_ham_left
   import qvr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire quat_type rot,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire comp_type in_x,
   input  wire comp_type in_y,
   input  wire comp_type in_z,
   output logic          out_valid,
   input  wire logic     out_ready,
   output pr_type        out_pr
);

   comp_type rw, rx, ry, rz;
   logic a_adv, b_adv;
   logic a_valid_ff, b_valid_ff;
   logic signed [PROD1_W-1:0] a_m_ff [12];
   logic signed [PROD1_W-1:0] a_m_in [12];
   pr_type b_pr_ff, b_pr_in;

   assign rw = rot.w;
   assign rx = rot.x;
   assign ry = rot.y;
   assign rz = rot.z;

   assign b_adv    = !b_valid_ff || out_ready;
   assign a_adv    = !a_valid_ff || b_adv;
   assign in_ready = a_adv;

   always_comb begin
      a_m_in[0]  = in_x * rw;
      a_m_in[1]  = in_y * rw;
      a_m_in[2]  = in_z * rw;
      a_m_in[3]  = in_x * rx;
      a_m_in[4]  = in_y * ry;
      a_m_in[5]  = in_z * rz;
      a_m_in[6]  = in_y * rz;
      a_m_in[7]  = in_z * ry;
      a_m_in[8]  = in_z * rx;
      a_m_in[9]  = in_x * rz;
      a_m_in[10] = in_x * ry;
      a_m_in[11] = in_y * rx;
   end

   // the scalar 1 of p brings in the bare quaternion components
   always_comb begin
      b_pr_in.w = pr_comp_type'(rw) - pr_comp_type'(a_m_ff[3])
                - pr_comp_type'(a_m_ff[4]) - pr_comp_type'(a_m_ff[5]);
      b_pr_in.x = pr_comp_type'(rx) + pr_comp_type'(a_m_ff[0])
                + pr_comp_type'(a_m_ff[6]) - pr_comp_type'(a_m_ff[7]);
      b_pr_in.y = pr_comp_type'(ry) + pr_comp_type'(a_m_ff[1])
                + pr_comp_type'(a_m_ff[8]) - pr_comp_type'(a_m_ff[9]);
      b_pr_in.z = pr_comp_type'(rz) + pr_comp_type'(a_m_ff[2])
                + pr_comp_type'(a_m_ff[10]) - pr_comp_type'(a_m_ff[11]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (a_adv) a_valid_ff <= in_valid;
         if (b_adv) b_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_adv && in_valid) a_m_ff <= a_m_in;
      if (b_adv && a_valid_ff) b_pr_ff <= b_pr_in;
   end

   assign out_valid = b_valid_ff;
   assign out_pr    = b_pr_ff;

endmodule

`default_nettype wire

/* hw/rtl/qvr_ham_right.sv */
`default_nettype none

// vector part of conj(r) * pr: products in the first stage, sums in the second
module qvr_ham_right
   import qvr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire quat_type rot,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire pr_type   in_pr,
   output logic          out_valid,
   input  wire logic     out_ready,
   output acc_type       out_acc
);

   comp_type rw, rx, ry, rz;
   pr_comp_type p0, p1, p2, p3;
   logic c_adv, d_adv;
   logic c_valid_ff, d_valid_ff;
   logic signed [PROD2_W-1:0] c_m_ff [12];
   logic signed [PROD2_W-1:0] c_m_in [12];
   acc_type d_acc_ff, d_acc_in;

   assign rw = rot.w;
   assign rx = rot.x;
   assign ry = rot.y;
   assign rz = rot.z;
   assign p0 = in_pr.w;
   assign p1 = in_pr.x;
   assign p2 = in_pr.y;
   assign p3 = in_pr.z;

   assign d_adv    = !d_valid_ff || out_ready;
   assign c_adv    = !c_valid_ff || d_adv;
   assign in_ready = c_adv;

   always_comb begin
      c_m_in[0]  = rx * p0;
      c_m_in[1]  = rw * p1;
      c_m_in[2]  = ry * p3;
      c_m_in[3]  = rz * p2;
      c_m_in[4]  = ry * p0;
      c_m_in[5]  = rw * p2;
      c_m_in[6]  = rz * p1;
      c_m_in[7]  = rx * p3;
      c_m_in[8]  = rz * p0;
      c_m_in[9]  = rw * p3;
      c_m_in[10] = rx * p2;
      c_m_in[11] = ry * p1;
   end

   always_comb begin
      d_acc_in.x = acc_comp_type'(c_m_ff[1]) - acc_comp_type'(c_m_ff[0])
                 + acc_comp_type'(c_m_ff[3]) - acc_comp_type'(c_m_ff[2]);
      d_acc_in.y = acc_comp_type'(c_m_ff[5]) - acc_comp_type'(c_m_ff[4])
                 + acc_comp_type'(c_m_ff[7]) - acc_comp_type'(c_m_ff[6]);
      d_acc_in.z = acc_comp_type'(c_m_ff[9]) - acc_comp_type'(c_m_ff[8])
                 + acc_comp_type'(c_m_ff[11]) - acc_comp_type'(c_m_ff[10]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else begin
         if (c_adv) c_valid_ff <= in_valid;
         if (d_adv) d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (c_adv && in_valid) c_m_ff <= c_m_in;
      if (d_adv && c_valid_ff) d_acc_ff <= d_acc_in;
   end

   assign out_valid = d_valid_ff;
   assign out_acc   = d_acc_ff;

endmodule

`default_nettype wire

/* hw/rtl/qvr_round_sat.sv */
`default_nettype none

// scale down by 2^28 toward zero and clamp to 16 bits, output register
module qvr_round_sat
   import qvr_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire acc_type in_acc,
   output logic         out_valid,
   input  wire logic    out_ready,
   output comp_type     out_x,
   output comp_type     out_y,
   output comp_type     out_z,
   output logic         out_clipped
);

   logic e_adv;
   logic e_valid_ff;
   comp_type e_x_ff, e_y_ff, e_z_ff;
   comp_type e_x_in, e_y_in, e_z_in;
   logic e_clip_ff, e_clip_in;
   logic clip_x, clip_y, clip_z;

   function automatic comp_type scale_sat(input acc_comp_type acc, output logic clip);
      logic [ACC_W-1:0] bias;
      logic [ACC_W-1:0] biased;
      logic [Q_W-1:0]   q;
      logic [Q_W-COMP_W:0] hi;
      bias   = {{Q_W{1'b0}}, {SHIFT_W{acc[ACC_W-1]}}};
      biased = acc + bias;
      q      = biased[ACC_W-1:SHIFT_W];
      hi     = q[Q_W-1:COMP_W-1];
      clip   = !((&hi) || !(|hi));
      if (clip) begin
         scale_sat = q[Q_W-1] ? {1'b1, {(COMP_W-1){1'b0}}} : {1'b0, {(COMP_W-1){1'b1}}};
      end else begin
         scale_sat = q[COMP_W-1:0];
      end
   endfunction

   assign e_adv    = !e_valid_ff || out_ready;
   assign in_ready = e_adv;

   always_comb begin
      e_x_in    = scale_sat(in_acc.x, clip_x);
      e_y_in    = scale_sat(in_acc.y, clip_y);
      e_z_in    = scale_sat(in_acc.z, clip_z);
      e_clip_in = clip_x || clip_y || clip_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e_valid_ff <= 1'b0;
      end else if (e_adv) begin
         e_valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (e_adv && in_valid) begin
         e_x_ff    <= e_x_in;
         e_y_ff    <= e_y_in;
         e_z_ff    <= e_z_in;
         e_clip_ff <= e_clip_in;
      end
   end

   assign out_valid   = e_valid_ff;
   assign out_x       = e_x_ff;
   assign out_y       = e_y_ff;
   assign out_z       = e_z_ff;
   assign out_clipped = e_clip_ff;

endmodule

`default_nettype wire

/* hw/rtl/qvr_checker.sv */
`default_nettype none

module qvr_checker
   import qvr_pkg::*;
(
   input wire logic     clock,
   input wire logic     reset,
   input wire logic     req_valid,
   input wire logic     req_stall,
   input wire logic     rsp_valid,
   input wire logic     rsp_stall,
   input wire comp_type rsp_out_x,
   input wire comp_type rsp_out_y,
   input wire comp_type rsp_out_z,
   input wire logic     rsp_clipped
);

   localparam int DEPTH = 5;

   logic [2:0] pending_ff, pending_in;
   logic req_xfer, rsp_xfer;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_xfer && !rsp_xfer) pending_in = pending_ff + 3'd1;
      if (!req_xfer && rsp_xfer) pending_in = pending_ff - 3'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a stalled response holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_x)
         && $stable(rsp_out_y) && $stable(rsp_out_z) && $stable(rsp_clipped))
      else $error("response changed while stalled");

   // no response without an outstanding request, never more than the stages hold
   a_pending: assert property (@(posedge clock) disable iff (reset)
      (pending_ff <= 3'(DEPTH)) && (!rsp_valid || pending_ff != 3'd0))
      else $error("response count does not match requests");

   // an open output lets every stage move, so the input is never held off
   a_no_backpressure: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled with output free");

   // a clipped result carries a clamp value in at least one coordinate
   a_clip_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clipped |->
         rsp_out_x == 16'sh7fff || rsp_out_x == 16'sh8000 ||
         rsp_out_y == 16'sh7fff || rsp_out_y == 16'sh8000 ||
         rsp_out_z == 16'sh7fff || rsp_out_z == 16'sh8000)
      else $error("clipped set without a clamped coordinate");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

bind quaternion_vector_rotate qvr_checker u_qvr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_out_x   (rsp_out_x),
   .rsp_out_y   (rsp_out_y),
   .rsp_out_z   (rsp_out_z),
   .rsp_clipped (rsp_clipped)
);

`default_nettype wire

/* verif/tb_top.sv */
module tb_top;
   import qvr_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_CYCLES    = 60;
   localparam int END_CYCLES     = 20;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_ITEMS    = 70;
   localparam longint COORD_MAX  = 32767;
   localparam longint COORD_MIN  = -32768;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
   } vec3_type;

   typedef struct packed {
      comp_type x;
      comp_type y;
      comp_type z;
      logic     clipped;
   } rotated_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   comp_type    req_vec_x   = '0;
   comp_type    req_vec_y   = '0;
   comp_type    req_vec_z   = '0;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   comp_type    rsp_out_x;
   comp_type    rsp_out_y;
   comp_type    rsp_out_z;
   logic        rsp_clipped;
   logic        csr_valid   = 1'b0;
   logic        csr_ready;
   csr_idx_type csr_index   = '0;
   comp_type    csr_data    = '0;

   // rotation quaternion as the block should hold it, indexed by register
   comp_type rot_cfg [4] = '{ONE_Q14, '0, '0, '0};

   vec3_type    pending_vecs [$];
   rotated_type rotated_expect [$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_trigger       = 0;
   int hold_seen          = 0;
   int hold_left          = 0;
   int mismatch_count     = 0;
   int idle_cycles        = 0;
   int items_queued       = 0;
   int items_checked      = 0;

   quaternion_vector_rotate DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_vec_x   (req_vec_x),
      .req_vec_y   (req_vec_y),
      .req_vec_z   (req_vec_z),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_x   (rsp_out_x),
      .rsp_out_y   (rsp_out_y),
      .rsp_out_z   (rsp_out_z),
      .rsp_clipped (rsp_clipped),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic comp_type clamp_coord(input longint acc, inout logic sat);
      longint q;
      // signed division truncates toward zero
      q = acc / (longint'(1) << SHIFT_W);
      if (q > COORD_MAX) begin
         q   = COORD_MAX;
         sat = 1'b1;
      end else if (q < COORD_MIN) begin
         q   = COORD_MIN;
         sat = 1'b1;
      end
      return comp_type'(q);
   endfunction

   // vector part of conj(r) * ((1, v) * r), kept exact in 64 bits
   function automatic rotated_type rotate_vector(comp_type vx_in, comp_type vy_in,
                                                 comp_type vz_in);
      longint rw, rx, ry, rz, vx, vy, vz;
      longint pw, px, py, pz;
      longint ax, ay, az;
      logic sat;
      rotated_type res;
      rw = longint'(rot_cfg[REG_ROT_W[1:0]]);
      rx = longint'(rot_cfg[REG_ROT_X[1:0]]);
      ry = longint'(rot_cfg[REG_ROT_Y[1:0]]);
      rz = longint'(rot_cfg[REG_ROT_Z[1:0]]);
      vx = longint'(vx_in);
      vy = longint'(vy_in);
      vz = longint'(vz_in);
      pw = rw - vx * rx - vy * ry - vz * rz;
      px = vx * rw + rx + vy * rz - vz * ry;
      py = vy * rw + ry + vz * rx - vx * rz;
      pz = vz * rw + rz + vx * ry - vy * rx;
      ax = rw * px - rx * pw - ry * pz + rz * py;
      ay = rw * py - ry * pw - rz * px + rx * pz;
      az = rw * pz - rz * pw - rx * py + ry * px;
      sat = 1'b0;
      res.x = clamp_coord(ax, sat);
      res.y = clamp_coord(ay, sat);
      res.z = clamp_coord(az, sat);
      res.clipped = sat;
      return res;
   endfunction

   function automatic comp_type extreme_coord();
      case ($urandom_range(4))
         0: return comp_type'(COORD_MAX);
         1: return comp_type'(COORD_MIN);
         2: return comp_type'(0);
         3: return comp_type'(-1);
         default: return comp_type'(1);
      endcase
   endfunction

   function automatic comp_type random_coord();
      int pick;
      pick = $urandom_range(9);
      if (pick < 5) begin
         return comp_type'($urandom);
      end else if (pick < 8) begin
         return comp_type'(int'($urandom_range(4096)) - 2048);
      end
      return extreme_coord();
   endfunction

   function automatic void add_vec(int x, int y, int z);
      vec3_type v;
      v.x = comp_type'(x);
      v.y = comp_type'(y);
      v.z = comp_type'(z);
      pending_vecs.push_back(v);
      items_queued++;
   endfunction

   // leaves csr_valid high so that back-to-back writes need no lowering
   task automatic write_csr(csr_idx_type idx, comp_type data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx <= REG_ROT_Z) begin
         rot_cfg[idx[1:0]] = data;
      end
   endtask

   task automatic load_rotation(int w, int x, int y, int z);
      write_csr(REG_ROT_W, comp_type'(w));
      write_csr(REG_ROT_X, comp_type'(x));
      write_csr(REG_ROT_Y, comp_type'(y));
      write_csr(REG_ROT_Z, comp_type'(z));
      csr_valid <= 1'b0;
   endtask

   task automatic load_random_rotation(int kind);
      int q [4];
      for (int i = 0; i < 4; i++) begin
         case (kind)
            0: q[i] = int'($urandom_range(23170)) - 11585;
            1: q[i] = int'(comp_type'($urandom));
            2: q[i] = int'(extreme_coord());
            default: begin
               // close to unit, dominated by the scalar part
               if (i == 0) begin
                  q[i] = int'($urandom_range(16384, 12000));
               end else begin
                  q[i] = int'($urandom_range(8192)) - 4096;
               end
            end
         endcase
      end
      load_rotation(q[0], q[1], q[2], q[3]);
   endtask

   // every queued vector has come back, so nothing is left in the block
   task automatic wait_drained();
      do @(posedge clock);
      while (items_checked != items_queued);
   endtask

   always @(posedge clock) begin : drive_req
      vec3_type next_vec;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            rotated_expect.push_back(rotate_vector(req_vec_x, req_vec_y, req_vec_z));
         end
         // a stalled transfer keeps its payload
         if (!req_valid || !req_stall) begin
            if (pending_vecs.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               next_vec = pending_vecs.pop_front();
               req_valid <= 1'b1;
               req_vec_x <= next_vec.x;
               req_vec_y <= next_vec.y;
               req_vec_z <= next_vec.z;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      rotated_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (rotated_expect.size() == 0) begin
            if (mismatch_count < 10) begin
               $display("unexpected response: got %0d %0d %0d clipped %0b",
                        rsp_out_x, rsp_out_y, rsp_out_z, rsp_clipped);
            end
            mismatch_count++;
         end else begin
            want = rotated_expect.pop_front();
            items_checked++;
            if (rsp_out_x !== want.x || rsp_out_y !== want.y || rsp_out_z !== want.z ||
                rsp_clipped !== want.clipped) begin
               if (mismatch_count < 10) begin
                  $display("mismatch: expected %0d %0d %0d clip %0b, got %0d %0d %0d clip %0b",
                           $signed(want.x), $signed(want.y), $signed(want.z), want.clipped,
                           rsp_out_x, rsp_out_y, rsp_out_z, rsp_clipped);
               end
               mismatch_count++;
            end
         end
      end
   end

   // long hold-off so the pipeline fills and the input stalls
   always @(posedge clock) begin : stall_rsp
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_stall <= 1'b1;
      end else if (hold_seen != hold_trigger) begin
         hold_seen <= hold_trigger;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < receiver_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   initial begin : stimulus
      int kind;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // identity rotation out of reset
      add_vec(0, 0, 0);
      add_vec(32767, 32767, 32767);
      add_vec(-32768, -32768, -32768);
      add_vec(1, -1, 12345);
      add_vec(-32768, 32767, 0);
      add_vec(21845, -21846, 4660);
      wait_drained();

      // zero quaternion gives a zero vector with no clip
      load_rotation(0, 0, 0, 0);
      add_vec(32767, -32768, 100);
      add_vec(1, 2, 3);
      wait_drained();

      load_rotation(32767, 32767, 32767, 32767);
      add_vec(32767, 32767, 32767);
      add_vec(-32768, 0, 32767);
      add_vec(1, 1, 1);
      wait_drained();

      load_rotation(-32768, -32768, -32768, -32768);
      add_vec(-32768, -32768, -32768);
      add_vec(0, 0, 1);
      wait_drained();

      // quarter turn about z
      load_rotation(11585, 0, 0, 11585);
      add_vec(16384, 0, 0);
      add_vec(0, 16384, 0);
      add_vec(32767, -32768, 5);
      wait_drained();

      // half turn about x
      load_rotation(0, 16384, 0, 0);
      add_vec(100, -200, 300);
      add_vec(-32768, 32767, -32768);
      wait_drained();

      // writes beyond the last register must leave the rotation alone
      write_csr(csr_idx_type'(4), comp_type'(32767));
      write_csr(csr_idx_type'(255), comp_type'(-32768));
      csr_valid <= 1'b0;
      add_vec(100, -200, 300);
      add_vec(7, 8, 9);
      wait_drained();

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph % 4)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
            end
            1: begin
               sender_idle_pct    = 80;
               receiver_stall_pct = 0;
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 80;
            end
            default: begin
               sender_idle_pct    = 15;
               receiver_stall_pct = 15;
            end
         endcase
         kind = (ph + ph / 4) % 4;
         load_random_rotation(kind);
         if (ph % 2 == 1) begin
            write_csr(csr_idx_type'($urandom_range(255, 4)), comp_type'($urandom));
            csr_valid <= 1'b0;
         end
         if (ph % 4 == 0) begin
            hold_trigger++;
         end
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            add_vec(int'(random_coord()), int'(random_coord()), int'(random_coord()));
         end
         wait_drained();
      end

      repeat (END_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

/* files.f */
hw/rtl/qvr_pkg.sv
hw/rtl/qvr_csr.sv
hw/rtl/qvr_ham_left.sv
hw/rtl/qvr_ham_right.sv
hw/rtl/qvr_round_sat.sv
hw/rtl/quaternion_vector_rotate.sv
hw/rtl/qvr_checker.sv
verif/tb_top.sv
